// ===== hdl/asc_pkg.sv =====
// Shared types and constants for the step counter.
`default_nettype none

package asc_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LIMIT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REST_THRESHOLD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_MEAN_DEV     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ACTIVE       = 3'd4;

    // Register reset values
    localparam logic [15:0] CLAMP_LIMIT_RST      = 16'd16384;
    localparam logic [31:0] REST_THRESHOLD_RST   = 32'd64424509;
    localparam logic [31:0] ACTIVE_THRESHOLD_RST = 32'd65095598;
    localparam logic [15:0] MIN_MEAN_DEV_RST     = 16'd1638;
    localparam logic [15:0] MIN_ACTIVE_RST       = 16'd45;

    // Operation codes on the sample channel
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_TOGGLE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Run modes
    localparam logic [1:0] MODE_CLEARED  = 2'd0;
    localparam logic [1:0] MODE_COUNTING = 2'd1;
    localparam logic [1:0] MODE_PAUSED   = 2'd2;

    // Width of the saturating distance sum
    localparam int DIST_W = 34;

    typedef struct packed {
        logic [15:0] clamp_limit;
        logic [31:0] rest_threshold;
        logic [31:0] active_threshold;
        logic [15:0] min_mean_deviation;
        logic [15:0] min_active_samples;
    } t_cfg;

endpackage

`default_nettype wire

// ===== hdl/asc_in_if.sv =====
// Sample channel: operation code and three axis values.
`default_nettype none

interface asc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;

    modport source (output valid, output op, output accel_x, output accel_y,
                    output accel_z, input ready);
    modport sink   (input valid, input op, input accel_x, input accel_y,
                    input accel_z, output ready);
endinterface

`default_nettype wire

// ===== hdl/asc_out_if.sv =====
// Result channel: step count, step flag and run mode.
`default_nettype none

interface asc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] steps;
    logic        step_seen;
    logic [1:0]  run_mode;

    modport source (output valid, output steps, output step_seen, output run_mode,
                    input ready);
    modport sink   (input valid, input steps, input step_seen, input run_mode,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/asc_cfg_if.sv =====
// Configuration write channel: register index and write data.
`default_nettype none

interface asc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [asc_pkg::CFG_IDX_W-1:0]   index;
    logic [asc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/asc_cfg.sv =====
// Configuration register bank for the step counter.
`default_nettype none

module asc_cfg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    asc_cfg_if.sink            i_cfg,
    output asc_pkg::t_cfg      o_cfg
);
    import asc_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clamp_limit        <= CLAMP_LIMIT_RST;
            r_cfg.rest_threshold     <= REST_THRESHOLD_RST;
            r_cfg.active_threshold   <= ACTIVE_THRESHOLD_RST;
            r_cfg.min_mean_deviation <= MIN_MEAN_DEV_RST;
            r_cfg.min_active_samples <= MIN_ACTIVE_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_CLAMP_LIMIT:      r_cfg.clamp_limit        <= i_cfg.data[15:0];
                REG_REST_THRESHOLD:   r_cfg.rest_threshold     <= i_cfg.data;
                REG_ACTIVE_THRESHOLD: r_cfg.active_threshold   <= i_cfg.data;
                REG_MIN_MEAN_DEV:     r_cfg.min_mean_deviation <= i_cfg.data[15:0];
                REG_MIN_ACTIVE:       r_cfg.min_active_samples <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/asc_mul.sv =====
// Shared unsigned multiplier with a registered product.
`default_nettype none

module asc_mul #(
    parameter int W = 17
) (
    input  wire logic           i_clk,
    input  wire logic [W-1:0]   i_a,
    input  wire logic [W-1:0]   i_b,
    output logic      [2*W-1:0] o_p
);

    always_ff @(posedge i_clk) begin
        o_p <= (2*W)'(i_a) * (2*W)'(i_b);
    end

endmodule

`default_nettype wire

// ===== hdl/asc_sqrt.sv =====
// Iterative floor square root, one root bit per cycle.
`default_nettype none

module asc_sqrt #(
    parameter int RADW = 36
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [RADW-1:0]     i_rad,
    output logic                     o_done,
    output logic      [RADW/2-1:0]   o_root
);
    localparam int ROOTW = RADW / 2;
    localparam int RW    = ROOTW + 2;
    localparam int CW    = $clog2(ROOTW + 1);

    logic [RADW-1:0]  r_rad;
    logic [RW-1:0]    r_rem;
    logic [ROOTW-1:0] r_root;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [RW-1:0]    rem_sh;
    logic [RW-1:0]    trial;
    logic             fits;

    // Bring down the next two radicand bits and try a one in the root
    always_comb begin
        rem_sh = {r_rem[RW-3:0], r_rad[RADW-1:RADW-2]};
        trial  = {r_root, 2'b01};
        fits   = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(ROOTW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RADW-3:0], 2'b00};
            r_rem  <= fits ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[ROOTW-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

// ===== hdl/accel_step_counter.sv =====
// Top level of the accelerometer step counter: sequencer and detector state.
//
// Channels: i_in takes one beat per event (op = sample, start/pause toggle
// or clear, with three signed axis values); o_out returns exactly one beat
// per accepted input beat with the step count, a step flag and the run mode.
// i_cfg writes one of five registers (clamp limit, rest and active
// thresholds on the squared magnitude, least mean deviation, least active
// sample count); it is always ready. The user must keep it written only
// between events; the block itself does not enforce this. A toggle,
// clear, paused or cleared sample, or an unused op code goes straight
// to the result state. A counted sample runs three squares of the held
// axes through the shared multiplier and a decision state; in a movement
// phase it then squares the three distances from the rest vector and
// runs the bit-serial square root. The end of a phase adds one multiply
// for the mean test. One event is in work at a time; i_in is ready only when idle.
// Reset clears the run mode, detector state and counters and loads the
// register defaults. A result that o_out does not take holds in the output
// register; the next event is still accepted and holds before its result.
`default_nettype none

module accel_step_counter #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    asc_in_if.sink    i_in,
    asc_out_if.source o_out,
    asc_cfg_if.sink   i_cfg
);
    import asc_pkg::*;

    localparam int SW   = SAMPLE_BITS;
    localparam int XW   = (SW > 16) ? SW : 16;          // axis compare width
    localparam int DW   = SW + 1;                        // axis difference
    localparam int MW0  = (DW > 16) ? DW : 16;
    localparam int MW   = (MW0 > COUNT_BITS) ? MW0 : COUNT_BITS;
    localparam int PW   = 2 * MW;                        // product width
    localparam int AW   = 2 * SW + 4;                    // sum of three squares
    localparam int TW   = (AW > 32) ? AW : 32;           // threshold compare
    localparam int RTW  = AW / 2;                        // root width
    localparam int CPW  = (PW > DIST_W) ? PW : DIST_W;   // mean test compare
    localparam int CNW  = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAG,
        S_DECIDE,
        S_DIST,
        S_ROOT_GO,
        S_ROOT,
        S_MEAN,
        S_DONE
    } t_state;

    // The mean test has no tail state of its own: S_MEAN both issues and tests, told apart by r_chk
    t_cfg cfg;

    t_state                 r_state,       n_state;
    logic                   r_chk,         n_chk;
    logic [1:0]             r_k,           n_k;
    logic [AW-1:0]          r_acc,         n_acc;
    logic [1:0]             r_mode,        n_mode;
    logic                   r_moving,      n_moving;
    logic signed [SW-1:0]   r_raw  [3];
    logic signed [SW-1:0]   n_raw  [3];
    logic signed [SW-1:0]   r_held [3];
    logic signed [SW-1:0]   n_held [3];
    logic signed [SW-1:0]   r_rest [3];
    logic signed [SW-1:0]   n_rest [3];
    logic [COUNT_BITS-1:0]  r_cnt,         n_cnt;
    logic [DIST_W-1:0]      r_sum,         n_sum;
    logic [COUNT_BITS-1:0]  r_step_total,  n_step_total;
    logic                   r_step,        n_step;
    logic                   r_out_valid,   n_out_valid;
    logic [15:0]            r_out_steps,   n_out_steps;
    logic                   r_out_seen,    n_out_seen;
    logic [1:0]             r_out_mode,    n_out_mode;

    logic signed [SW-1:0]   in_raw   [3];
    logic [XW-1:0]          in_ext   [3];
    logic [SW-1:0]          held_mag [3];
    logic signed [DW-1:0]   diff     [3];
    logic [DW-1:0]          diff_mag [3];

    logic [MW-1:0]          mul_a, mul_b;
    logic [PW-1:0]          mul_p;
    logic                   sq_start;
    logic                   sq_done;
    logic [RTW-1:0]         sq_root;
    logic [DIST_W:0]        sum_ext;
    logic                   in_beat;

    asc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    asc_mul #(.W(MW)) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    asc_sqrt #(.RADW(AW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (r_acc),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // Take the low SAMPLE_BITS of each axis as a signed value
    always_comb begin
        in_ext[0] = XW'($unsigned(i_in.accel_x));
        in_ext[1] = XW'($unsigned(i_in.accel_y));
        in_ext[2] = XW'($unsigned(i_in.accel_z));
        for (int k = 0; k < 3; k++) begin
            in_raw[k] = $signed(in_ext[k][SW-1:0]);
        end
    end

    // Per-axis magnitudes feeding the shared multiplier
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            held_mag[k] = r_held[k][SW-1] ? $unsigned(-r_held[k]) : $unsigned(r_held[k]);
            diff[k]     = DW'(r_held[k]) - DW'(r_rest[k]);
            diff_mag[k] = diff[k][DW-1] ? $unsigned(-diff[k]) : $unsigned(diff[k]);
        end
    end

    // Multiplier operand select: squares of held axes, squares of distances,
    // or the mean threshold times the active sample count
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MAG: begin
                case (r_k)
                    2'd0:    mul_a = MW'(held_mag[0]);
                    2'd1:    mul_a = MW'(held_mag[1]);
                    2'd2:    mul_a = MW'(held_mag[2]);
                    default: mul_a = '0;
                endcase
                mul_b = mul_a;
            end
            S_DIST: begin
                case (r_k)
                    2'd0:    mul_a = MW'(diff_mag[0]);
                    2'd1:    mul_a = MW'(diff_mag[1]);
                    2'd2:    mul_a = MW'(diff_mag[2]);
                    default: mul_a = '0;
                endcase
                mul_b = mul_a;
            end
            S_MEAN: begin
                mul_a = MW'(cfg.min_mean_deviation);
                mul_b = MW'(r_cnt);
            end
            default: ;
        endcase
    end

    assign in_beat  = i_in.valid && (r_state == S_IDLE);
    assign sq_start = (r_state == S_ROOT_GO);
    assign sum_ext  = {1'b0, r_sum} + (DIST_W + 1)'(sq_root);

    always_comb begin
        n_state      = r_state;
        n_chk        = r_chk;
        n_k          = r_k;
        n_acc        = r_acc;
        n_mode       = r_mode;
        n_moving     = r_moving;
        n_raw        = r_raw;
        n_held       = r_held;
        n_rest       = r_rest;
        n_cnt        = r_cnt;
        n_sum        = r_sum;
        n_step_total = r_step_total;
        n_step       = r_step;
        n_out_valid  = r_out_valid;
        n_out_steps  = r_out_steps;
        n_out_seen   = r_out_seen;
        n_out_mode   = r_out_mode;

        // Drop the result beat once the receiver takes it
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_step  = 1'b0;
                    n_raw   = in_raw;
                    n_state = S_DONE;
                    case (i_in.op)
                        OP_TOGGLE: begin
                            n_mode = (r_mode == MODE_COUNTING) ? MODE_PAUSED : MODE_COUNTING;
                        end
                        OP_CLEAR: begin
                            n_mode       = MODE_CLEARED;
                            n_step_total = '0;
                        end
                        OP_SAMPLE: begin
                            if (r_mode == MODE_COUNTING) begin
                                // Hold an axis whose new value reaches the clamp limit
                                for (int k = 0; k < 3; k++) begin
                                    if ($signed(XW'(in_raw[k])) <
                                        $signed(XW'($signed(cfg.clamp_limit)))) begin
                                        n_held[k] = in_raw[k];
                                    end
                                end
                                n_k     = '0;
                                n_acc   = '0;
                                n_state = S_MAG;
                            end else if (r_mode == MODE_CLEARED) begin
                                n_step_total = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_MAG, S_DIST: begin
                // Issue one square per cycle, add the previous one
                if (r_k != 2'd0) begin
                    n_acc = r_acc + AW'(mul_p);
                end
                if (r_k == 2'd3) begin
                    n_state = (r_state == S_MAG) ? S_DECIDE : S_ROOT_GO;
                end else begin
                    n_k = r_k + 2'd1;
                end
            end

            S_DECIDE: begin
                n_state = S_DONE;
                if (!r_moving) begin
                    if (TW'(r_acc) < TW'(cfg.rest_threshold)) begin
                        n_rest = r_raw;
                    end else if (TW'(r_acc) >= TW'(cfg.active_threshold)) begin
                        n_moving = 1'b1;
                    end
                end else if (TW'(r_acc) >= TW'(cfg.active_threshold)) begin
                    n_k     = '0;
                    n_acc   = '0;
                    n_state = S_DIST;
                end else if (r_cnt != '0) begin
                    n_chk   = 1'b0;
                    n_state = S_MEAN;
                end else begin
                    n_cnt    = '0;
                    n_sum    = '0;
                    n_moving = 1'b0;
                end
            end

            S_ROOT_GO: begin
                n_state = S_ROOT;
            end

            S_ROOT: begin
                if (sq_done) begin
                    n_sum   = sum_ext[DIST_W] ? '1 : sum_ext[DIST_W-1:0];
                    n_cnt   = (r_cnt != '1) ? r_cnt + 1'b1 : r_cnt;
                    n_state = S_DONE;
                end
            end

            S_MEAN: begin
                // With r_chk low it issues the product; with r_chk set it tests the registered product
                if (!r_chk) begin
                    n_chk = 1'b1;
                end else begin
                    if ((CPW'(r_sum) >= CPW'(mul_p)) &&
                        (CNW'(r_cnt) >= CNW'(cfg.min_active_samples))) begin
                        n_step       = 1'b1;
                        n_step_total = (r_step_total != '1) ? r_step_total + 1'b1
                                                            : r_step_total;
                    end
                    n_cnt    = '0;
                    n_sum    = '0;
                    n_moving = 1'b0;
                    n_state  = S_DONE;
                end
            end

            S_DONE: begin
                // Hold until the output register is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_steps = 16'(r_step_total);
                    n_out_seen  = r_step;
                    n_out_mode  = r_mode;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_chk        <= 1'b0;
            r_k          <= '0;
            r_mode       <= MODE_CLEARED;
            r_moving     <= 1'b0;
            r_cnt        <= '0;
            r_sum        <= '0;
            r_step_total <= '0;
            r_step       <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_held[k] <= '0;
                r_rest[k] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_chk        <= n_chk;
            r_k          <= n_k;
            r_mode       <= n_mode;
            r_moving     <= n_moving;
            r_cnt        <= n_cnt;
            r_sum        <= n_sum;
            r_step_total <= n_step_total;
            r_step       <= n_step;
            r_out_valid  <= n_out_valid;
            r_held       <= n_held;
            r_rest       <= n_rest;
        end
        r_acc       <= n_acc;
        r_raw       <= n_raw;
        r_out_steps <= n_out_steps;
        r_out_seen  <= n_out_seen;
        r_out_mode  <= n_out_mode;
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.steps     = r_out_steps;
    assign o_out.step_seen = r_out_seen;
    assign o_out.run_mode  = r_out_mode;

    // Phase accumulators are empty outside a movement phase
    a_idle_phase_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_moving |-> (r_cnt == '0) && (r_sum == '0))
        else $error("phase accumulators not empty outside movement");

    // The root unit finishes only while the sequencer waits for it
    a_root_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_done |-> (r_state == S_ROOT))
        else $error("square root finished outside its wait state");

    // A step is only reported in counting mode
    a_step_counting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.step_seen) |-> (o_out.run_mode == MODE_COUNTING))
        else $error("step reported while not counting");

    // The step total moves only on a passed mean test or a clear
    a_total_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step_total != $past(r_step_total)) |->
            ((r_step_total == '0) || ($past(r_state) == S_MEAN)))
        else $error("step total changed outside a step or clear");

endmodule

`default_nettype wire
